### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, with and without reset qualification
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ADPCM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("adpcm assertion failed");

`define ADPCM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("adpcm assertion failed");

`else

`define ADPCM_ASSERT(lbl, clk, rstn, prop)

`define ADPCM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### rtl/core/adpcm_pkg.sv
// ----------------------------------------------------------------------------
// adpcm package
// shared types, register codes and decode tables of the adpcm decoder
// ----------------------------------------------------------------------------
package adpcm_pkg;

    localparam int STEP_IDX_W = 7;
    localparam int PCM_W      = 16;
    localparam int STEP_W     = 15;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [STEP_IDX_W-1:0] STEP_IDX_MAX = 7'd88;

    localparam logic [0:0] REG_CHANNELS   = 1'b0;
    localparam logic [1:0] CHAN_STEREO    = 2'd2;
    localparam logic [1:0] CHANNELS_RESET = 2'd1;

    typedef struct packed {
        logic signed [PCM_W-1:0]      pred;
        logic        [STEP_IDX_W-1:0] idx;
    } t_chan_state;

    localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
        15'h0007, 15'h0008, 15'h0009, 15'h000A, 15'h000B, 15'h000C, 15'h000D, 15'h000E,
        15'h0010, 15'h0011, 15'h0013, 15'h0015, 15'h0017, 15'h0019, 15'h001C, 15'h001F,
        15'h0022, 15'h0025, 15'h0029, 15'h002D, 15'h0032, 15'h0037, 15'h003C, 15'h0042,
        15'h0049, 15'h0050, 15'h0058, 15'h0061, 15'h006B, 15'h0076, 15'h0082, 15'h008F,
        15'h009D, 15'h00AD, 15'h00BE, 15'h00D1, 15'h00E6, 15'h00FD, 15'h0117, 15'h0133,
        15'h0151, 15'h0173, 15'h0198, 15'h01C1, 15'h01EE, 15'h0220, 15'h0256, 15'h0292,
        15'h02D4, 15'h031C, 15'h036C, 15'h03C3, 15'h0424, 15'h048E, 15'h0502, 15'h0583,
        15'h0610, 15'h06AB, 15'h0756, 15'h0812, 15'h08E0, 15'h09C3, 15'h0ABD, 15'h0BD0,
        15'h0CFF, 15'h0E4C, 15'h0FBA, 15'h114C, 15'h1307, 15'h14EE, 15'h1706, 15'h1954,
        15'h1BDC, 15'h1EA5, 15'h21B6, 15'h2515, 15'h28CA, 15'h2CDF, 15'h315B, 15'h364B,
        15'h3BB9, 15'h41B2, 15'h4844, 15'h4F7E, 15'h5771, 15'h602F, 15'h69CE, 15'h7462,
        15'h7FFF
    };

    localparam logic signed [4:0] IDX_ADJUST [0:7] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

endpackage

### rtl/core/adpcm_byte_if.sv
// ----------------------------------------------------------------------------
// adpcm byte channel
// valid/ready channel carrying one coded byte per transfer
// ----------------------------------------------------------------------------
interface adpcm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

### rtl/core/adpcm_pcm_if.sv
// ----------------------------------------------------------------------------
// adpcm pcm channel
// valid/ready channel carrying two signed 16-bit samples per transfer
// ----------------------------------------------------------------------------
interface adpcm_pcm_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_first;
    logic signed [15:0] sample_second;

    modport source (output valid, output sample_first, output sample_second, input ready);
    modport sink (input valid, input sample_first, input sample_second, output ready);
endinterface

### rtl/core/adpcm_nibble.sv
// ----------------------------------------------------------------------------
// adpcm nibble decoder
// one 4-bit code against one predictor state, giving the next state
// ----------------------------------------------------------------------------
module adpcm_nibble (
    input  logic [3:0]             i_code,
    input  adpcm_pkg::t_chan_state i_state,
    output adpcm_pkg::t_chan_state o_state
);

    logic [2:0]                          mag;
    logic [adpcm_pkg::STEP_IDX_W-1:0]    idx_clamped;
    logic [adpcm_pkg::STEP_W-1:0]        step;
    logic [adpcm_pkg::STEP_W+3:0]        prod;
    logic [adpcm_pkg::PCM_W-1:0]         delta;
    logic signed [adpcm_pkg::PCM_W+1:0]  sum;
    logic signed [adpcm_pkg::STEP_IDX_W:0] idx_next;

    always_comb begin
        mag         = i_code[2:0];
        idx_clamped = (i_state.idx > adpcm_pkg::STEP_IDX_MAX) ?
                      adpcm_pkg::STEP_IDX_MAX : i_state.idx;
        step        = adpcm_pkg::STEP_TABLE[idx_clamped];
        prod        = {15'd0, mag, 1'b1} * {4'd0, step};
        delta       = prod[adpcm_pkg::STEP_W+3:3];

        if (i_code[3]) begin
            sum = {{2{i_state.pred[15]}}, i_state.pred} - $signed({2'b00, delta});
        end else begin
            sum = {{2{i_state.pred[15]}}, i_state.pred} + $signed({2'b00, delta});
        end

        if (sum < -18'sd32768) begin
            o_state.pred = 16'sh8000;
        end else if (sum > 18'sd32767) begin
            o_state.pred = 16'sh7FFF;
        end else begin
            o_state.pred = sum[15:0];
        end

        idx_next = $signed({1'b0, idx_clamped}) +
                   {{3{adpcm_pkg::IDX_ADJUST[mag][4]}}, adpcm_pkg::IDX_ADJUST[mag]};
        if (idx_next < 8'sd0) begin
            o_state.idx = '0;
        end else if (idx_next > $signed({1'b0, adpcm_pkg::STEP_IDX_MAX})) begin
            o_state.idx = adpcm_pkg::STEP_IDX_MAX;
        end else begin
            o_state.idx = idx_next[adpcm_pkg::STEP_IDX_W-1:0];
        end
    end

endmodule

### rtl/core/adpcm_regs.sv
// ----------------------------------------------------------------------------
// adpcm register file
// apb-style configuration port holding the channel count register
// ----------------------------------------------------------------------------
module adpcm_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adpcm_pkg::APB_AW-1:0]  paddr,
    input  logic [adpcm_pkg::APB_DW-1:0]  pwdata,
    output logic [adpcm_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output logic [1:0]                    o_channels
);

    logic [1:0] r_channels;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready &&
                    (paddr[2] == adpcm_pkg::REG_CHANNELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels <= adpcm_pkg::CHANNELS_RESET;
        end else if (wr_en) begin
            r_channels <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == adpcm_pkg::REG_CHANNELS) begin
            prdata = {30'd0, r_channels};
        end
    end

    assign o_channels = r_channels;

endmodule

### rtl/core/adpcm_nibble_audio_decoder.sv
// ----------------------------------------------------------------------------
// adpcm nibble audio decoder
// 4-bit adaptive differential pcm decoder, one coded byte to two samples
// ----------------------------------------------------------------------------
// i_code takes one coded byte per transfer; the high nibble is decoded
// first, then the low nibble. o_pcm gives one transfer per byte with both
// samples. the channels register (apb, address 0) selects mono (shared
// left predictor) or stereo (value 2: high nibble left, low nibble right).
// an input transfer passes through the input register, then through the
// two chained nibble decoders into the result register, which drives
// o_pcm.valid. throughput is one byte per cycle while o_pcm does not
// stall, set by the predictor feedback loop, which closes through both
// nibble decoders. when o_pcm stalls, the input register still takes one
// more byte and then i_code.ready drops until the result is taken. reset
// clears both predictors and step indexes, empties both registers and
// sets the channels register to mono.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adpcm_nibble_audio_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    adpcm_byte_if.sink                    i_code,
    adpcm_pcm_if.source                   o_pcm,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adpcm_pkg::APB_AW-1:0]  paddr,
    input  logic [adpcm_pkg::APB_DW-1:0]  pwdata,
    output logic [adpcm_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    logic [1:0]             channels;
    logic                   stereo;
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_out_valid;
    logic signed [15:0]     r_sample_first;
    logic signed [15:0]     r_sample_second;
    adpcm_pkg::t_chan_state r_left;
    adpcm_pkg::t_chan_state r_right;
    adpcm_pkg::t_chan_state first_st;
    adpcm_pkg::t_chan_state second_in;
    adpcm_pkg::t_chan_state second_st;
    logic                   advance;
    logic                   decode;

    adpcm_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_channels (channels)
    );

    assign stereo    = (channels == adpcm_pkg::CHAN_STEREO);
    assign advance   = !r_out_valid || o_pcm.ready;
    assign decode    = r_in_valid && advance;
    assign second_in = stereo ? r_right : first_st;

    assign i_code.ready = !r_in_valid || advance;

    adpcm_nibble u_first (
        .i_code  (r_in_byte[7:4]),
        .i_state (r_left),
        .o_state (first_st)
    );

    adpcm_nibble u_second (
        .i_code  (r_in_byte[3:0]),
        .i_state (second_in),
        .o_state (second_st)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_code.ready) begin
            r_in_valid <= i_code.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_code.valid && i_code.ready) begin
            r_in_byte <= i_code.code_byte;
        end
    end

    // predictor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
        end else if (decode) begin
            if (stereo) begin
                r_left  <= first_st;
                r_right <= second_st;
            end else begin
                r_left  <= second_st;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (decode) begin
            r_sample_first  <= first_st.pred;
            r_sample_second <= second_st.pred;
        end
    end

    assign o_pcm.valid         = r_out_valid;
    assign o_pcm.sample_first  = r_sample_first;
    assign o_pcm.sample_second = r_sample_second;

    `ADPCM_ASSERT(a_left_idx_range, i_clk, i_rst_n, r_left.idx <= adpcm_pkg::STEP_IDX_MAX)
    `ADPCM_ASSERT(a_right_idx_range, i_clk, i_rst_n, r_right.idx <= adpcm_pkg::STEP_IDX_MAX)
    `ADPCM_ASSERT(a_mono_right_held, i_clk, i_rst_n, (decode && !stereo) |=> $stable(r_right))
    `ADPCM_ASSERT(a_out_from_decode, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_in_valid))
    `ADPCM_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid |-> i_code.ready)

endmodule
